/* rtl/fenwick_prefix_sum_kth_top_macros.svh */
// Assertion helpers for the Fenwick tree block.
// Each expects clk and rst in scope; checks are off while rst is high.
`ifndef FENWICK_PREFIX_SUM_KTH_TOP_MACROS_SVH
`define FENWICK_PREFIX_SUM_KTH_TOP_MACROS_SVH

// same-cycle implication
`define FPSK_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FPSK_LEADS_TO(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fpsk_pkg.sv */
package fpsk_pkg;

  localparam int NUM_POSITIONS_DEF = 1024;

  localparam int CMD_W = 2;
  localparam int IDX_W = 11;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;

  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_KTH    = 2'd2;

endpackage

/* rtl/fpsk_ram.sv */
// Simple dual-port RAM: one write port, one read port, registered read.
module fpsk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/fenwick_prefix_sum_kth_top.sv */
// A query walks at most log2(N)+1 nodes (11 for N = 1024) before its result is registered;
//   a kth search descends from the largest power of two not above N, one bit at a time.
// Flow: one word in flight; the next is taken after an update's walk ends, or once
//   the result is registered, later while out_stall holds the result.
// Reset: synchronous; afterwards a clearing pass writes zero to every node, with in_stall high throughout.
`include "fenwick_prefix_sum_kth_top_macros.svh"

module fenwick_prefix_sum_kth_top import fpsk_pkg::*; #(
  parameter int NUM_POSITIONS = NUM_POSITIONS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        cmd,
  input  logic [IDX_W-1:0]        index,
  input  logic signed [VAL_W-1:0] value,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    is_position,
  output logic signed [SUM_W-1:0] result
);

  // node address is position - 1
  localparam int AW = $clog2(NUM_POSITIONS);
  // positions run up to 2N while rippling an update past the end
  localparam int PW = $clog2(2 * NUM_POSITIONS + 1);
  // compare width for the raw index against N
  localparam int CW = (PW > IDX_W) ? PW : IDX_W;

  localparam logic [PW-1:0] N_P = PW'(NUM_POSITIONS);
  localparam logic [CW-1:0] N_C = CW'(NUM_POSITIONS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_POSITIONS - 1);
  // largest power of two not above N: first kth step
  localparam logic [PW-1:0] TOP_STEP = PW'(1) << ($clog2(NUM_POSITIONS + 1) - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_QRY   = 3'd3;
  localparam logic [2:0] S_KTH   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state;
  logic [AW-1:0]    clr_addr;
  logic [PW-1:0]    pos;       // current tree position (kth: prefix found so far)
  logic [PW-1:0]    wpos;      // update: node whose read is in flight
  logic             rd_pend;   // a read issued last cycle returns now
  logic [PW-1:0]    step;      // kth: current power of two
  logic             phase;     // kth: 0 issue read, 1 compare
  logic             kind;      // 1 for kth word
  logic [SUM_W-1:0] operand;   // sign-extended delta or target
  logic [SUM_W-1:0] acc;       // running sum (kth: count so far, then answer)

  // node RAM hookup
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [SUM_W-1:0] ram_rdata;

  logic [PW-1:0]    low;
  logic [PW-1:0]    cand;
  logic [SUM_W-1:0] kth_sum;
  logic             kth_take;
  logic [CW-1:0]    idx_c;
  logic             out_free;

  fpsk_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NUM_POSITIONS)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    low      = pos & (~pos + PW'(1));
    cand     = pos | step;
    kth_sum  = acc + ram_rdata;
    kth_take = $signed(kth_sum) < $signed(operand);
    idx_c    = CW'(index);
  end

  // RAM port steering. Update writes node k while reading node k+lowbit(k);
  // the addresses strictly increase so they never collide.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_UPD: begin
        if (rd_pend) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(wpos - PW'(1));
          ram_wdata = ram_rdata + operand;
        end
        if (pos <= N_P) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(pos - PW'(1));
        end
      end
      S_QRY: begin
        if (pos != '0) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(pos - PW'(1));
        end
      end
      S_KTH: begin
        if (!phase && step != '0 && cand <= N_P) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(cand - PW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rd_pend   <= 1'b0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // S_DONE loads the output register itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            operand <= {{(SUM_W - VAL_W){value[VAL_W-1]}}, value};
            acc     <= '0;
            rd_pend <= 1'b0;
            phase   <= 1'b0;
            case (cmd)
              CMD_UPDATE: begin
                // index zero or past the end: dropped
                if (idx_c != '0 && idx_c <= N_C) begin
                  pos   <= PW'(idx_c);
                  state <= S_UPD;
                end
              end
              CMD_QUERY: begin
                pos   <= (idx_c > N_C) ? N_P : PW'(idx_c);
                kind  <= 1'b0;
                state <= S_QRY;
              end
              CMD_KTH: begin
                pos   <= '0;
                step  <= TOP_STEP;
                kind  <= 1'b1;
                state <= S_KTH;
              end
              default: ;
            endcase
          end
        end
        S_UPD: begin
          if (pos <= N_P) begin
            wpos    <= pos;
            rd_pend <= 1'b1;
            pos     <= pos + low;
          end else begin
            // last write-back goes out this cycle
            rd_pend <= 1'b0;
            state   <= S_IDLE;
          end
        end
        S_QRY: begin
          if (rd_pend) begin
            acc <= acc + ram_rdata;
          end
          if (pos != '0) begin
            pos     <= pos - low;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state   <= S_DONE;
          end
        end
        S_KTH: begin
          if (!phase) begin
            if (step == '0) begin
              acc   <= {{(SUM_W - PW){1'b0}}, pos + PW'(1)};
              state <= S_DONE;
            end else if (cand <= N_P) begin
              phase <= 1'b1;
            end else begin
              step <= step >> 1;
            end
          end else begin
            if (kth_take) begin
              pos <= cand;
              acc <= kth_sum;
            end
            step  <= step >> 1;
            phase <= 1'b0;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            is_position <= kind;
            result      <= acc;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // node RAM is written only by the clearing pass or an update
  `FPSK_IMPLIES(a_write_owner, ram_we, (state == S_CLEAR) || (state == S_UPD), "stray node write")

  // an update write-back always targets a real node
  `FPSK_IMPLIES(a_wpos_range, (state == S_UPD) && rd_pend,
    (wpos != '0) && (wpos <= N_P), "update write-back out of range")

  // a kth answer is a position in 1..N+1
  `FPSK_IMPLIES(a_kth_range, (state == S_DONE) && kind,
    (acc != '0) && (acc <= SUM_W'(NUM_POSITIONS + 1)), "kth answer out of range")

  // a finished word reaches the output register on the next edge once it is free
  `FPSK_LEADS_TO(a_done_out, (state == S_DONE) && out_free,
    out_valid && (state == S_IDLE), "finished word not presented")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Fenwick tree block: point update, prefix-sum query and kth search.
// A shadow tree in the testbench follows every accepted word and queues the
// answer it expects; the monitor compares each answer that leaves the block
// against the oldest queued one.
module tb_top import fpsk_pkg::*;;

  localparam int NPOS = NUM_POSITIONS_DEF;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NPOS);
  localparam logic [IDX_W-1:0] IDX_TOP  = '1;       // far past the last position
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;    // no such command, must be dropped

  // one expected answer
  typedef struct packed {
    logic              is_pos;
    logic [SUM_W-1:0]  val;
  } answer_t;

  logic clk;
  logic rst = 1'b1;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CMD_W-1:0]        cmd = CMD_UPDATE;
  logic [IDX_W-1:0]        index = '0;
  logic signed [VAL_W-1:0] value = '0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    is_position;
  logic signed [SUM_W-1:0] result;

  // shadow of the node store, positions 1..NPOS
  logic [SUM_W-1:0] tree_node [1:NPOS];
  answer_t pending_answers[$];
  int mismatch_count = 0;

  bit tail_quiet = 1'b0;  // no idling on either side
  bit in_calm = 1'b0;     // sender runs back to back for a stretch

  // sum of the non-negative deltas that test_counts_and_search feeds in range; sets kth targets
  logic [SUM_W-1:0] fed_total = '0;

  fenwick_prefix_sum_kth_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .index       (index),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_position (is_position),
    .result      (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- shadow tree

  // ripple a delta up through the covering nodes; index 0 and past-the-end drop out
  function automatic void tree_add(int unsigned pos, logic [SUM_W-1:0] delta);
    int unsigned i;
    if (pos == 0 || pos > NPOS) return;
    i = pos;
    while (i <= NPOS) begin
      tree_node[i] += delta;
      i += i & (~i + 1);
    end
  endfunction

  // sum of positions 1..upto, upto saturating at the last position
  function automatic logic [SUM_W-1:0] prefix_total(int unsigned upto);
    int unsigned i;
    logic [SUM_W-1:0] acc;
    acc = '0;
    i = (upto > NPOS) ? NPOS : upto;
    while (i != 0) begin
      acc += tree_node[i];
      i -= i & (~i + 1);
    end
    return acc;
  endfunction

  // binary descent: smallest position whose prefix reaches target (signed compare)
  function automatic logic [SUM_W-1:0] kth_position(logic [SUM_W-1:0] target);
    int unsigned stride, pos, cand;
    logic [SUM_W-1:0] run, trial;
    stride = 1;
    pos = 0;
    run = '0;
    while ((stride << 1) <= NPOS) stride = stride << 1;
    while (stride != 0) begin
      cand = pos | stride;
      if (cand <= NPOS) begin
        trial = run + tree_node[cand];
        if ($signed(trial) < $signed(target)) begin
          pos = cand;
          run = trial;
        end
      end
      stride = stride >> 1;
    end
    return SUM_W'(pos + 1);
  endfunction

  // apply one accepted word to the shadow tree, queue its answer if any
  function automatic void track_word(logic [CMD_W-1:0] c, logic [IDX_W-1:0] idx,
                                     logic [VAL_W-1:0] v);
    logic [SUM_W-1:0] wide;
    wide = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    case (c)
      CMD_UPDATE: tree_add(32'(idx), wide);
      CMD_QUERY:  pending_answers.push_back('{is_pos: 1'b0, val: prefix_total(32'(idx))});
      CMD_KTH:    pending_answers.push_back('{is_pos: 1'b1, val: kth_position(wide)});
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("%0t MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // both channels sampled at the edge, before any testbench drive lands
  always @(posedge clk) begin : monitor
    answer_t want;
    if (!rst) begin
      if (in_valid && !in_stall) track_word(cmd, index, value);
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          report_mismatch($sformatf("unexpected word is_position=%0b result=%0d",
                                    is_position, result));
        end else begin
          want = pending_answers.pop_front();
          if (is_position !== want.is_pos)
            report_mismatch($sformatf("is_position %0b, want %0b", is_position, want.is_pos));
          if (result !== want.val)
            report_mismatch($sformatf("result %0d, want %0d", result, $signed(want.val)));
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // output stall: random bursts, burst rate re-picked now and then,
  // zero rate meaning a stretch with no stall at all
  initial begin : out_stall_gen
    int burst_odds;
    burst_odds = 4;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 127) == 0)
        burst_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
      if (!tail_quiet && burst_odds != 0 && $urandom_range(1, burst_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // one word: optional idle gap, then hold it until taken
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] v);
    int gap;
    gap = 0;
    if (!tail_quiet && !in_calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    index    <= idx;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly in range, with a share of zero, the last position and past the end
  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return LAST_POS;
      2: return IDX_W'($urandom_range(NPOS + 1, int'(IDX_TOP)));
      3: return IDX_W'($urandom_range(1, 8));
      default: return IDX_W'($urandom_range(1, NPOS));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // fresh tree: zero answers, kth past the end, dropped words
  task automatic test_empty_tree();
    send_word(CMD_QUERY, '0, '0);
    send_word(CMD_QUERY, LAST_POS, '0);
    send_word(CMD_KTH, '0, '0);                    // target not above zero
    send_word(CMD_KTH, '0, 32'd1);                 // total short: last+1
    send_word(CMD_KTH, IDX_TOP, 32'h8000_0000);
    send_word(CMD_UPDATE, '0, 32'h7fff_ffff);      // index zero, dropped
    send_word(CMD_UPDATE, IDX_TOP, 32'h7fff_ffff); // past the end, dropped
    send_word(CMD_QUERY, IDX_TOP, '0);             // saturates
    send_word(CMD_UNUSED, 11'd1, 32'hffff_ffff);
    send_word(CMD_QUERY, 11'd1, '0);
  endtask

  // non-negative counts so that most kth searches land inside the tree
  task automatic test_counts_and_search(input int n_words);
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] v, top;
    for (int n = 0; n < n_words; n++) begin
      if (n % 64 == 0) in_calm = ($urandom_range(0, 2) == 0);
      idx = pick_index();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          v = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 32'h0fff_ffff)
                                           : $urandom_range(0, 50);
          if (idx != 0 && idx <= LAST_POS) fed_total += SUM_W'(v);
          send_word(CMD_UPDATE, idx, v);
        end
        4, 5, 6: send_word(CMD_QUERY, idx, '0);
        default: begin
          top = (fed_total > 64'h7fff_fffe) ? 32'h7fff_fffe : fed_total[VAL_W-1:0];
          case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = top + 1;
            default: v = (top == 0) ? 32'd1 : $urandom_range(1, top);
          endcase
          send_word(CMD_KTH, IDX_W'($urandom), v);
        end
      endcase
    end
    in_calm = 1'b0;
  endtask

  // sender holds off until everything in flight has come back
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    // let the monitor log the last accepted word first
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // field extremes, negative counts, signed targets
  task automatic test_extreme_values();
    send_word(CMD_UPDATE, 11'd1, 32'h7fff_ffff);
    send_word(CMD_UPDATE, LAST_POS, 32'h8000_0000);
    send_word(CMD_UPDATE, LAST_POS / 2, 32'hffff_ffff);
    send_word(CMD_QUERY, 11'd1, '0);
    send_word(CMD_QUERY, LAST_POS - 1, '0);
    send_word(CMD_QUERY, LAST_POS, '0);
    send_word(CMD_QUERY, IDX_TOP, '0);
    send_word(CMD_KTH, '0, 32'h7fff_ffff);
    send_word(CMD_KTH, '0, 32'h8000_0000);
    send_word(CMD_KTH, '0, 32'd1);
    send_word(CMD_KTH, IDX_TOP, '0);
    send_word(CMD_UPDATE, 11'd1, 32'h8000_0000);
    send_word(CMD_KTH, '0, 32'd1);
    send_word(CMD_QUERY, LAST_POS / 2, '0);
    send_word(CMD_UNUSED, IDX_TOP, 32'h7fff_ffff);
  endtask

  // anything the fields allow; the tail runs with no idling
  task automatic test_random_noise(input int n_words, input int quiet_words);
    logic [CMD_W-1:0] c;
    logic [IDX_W-1:0] idx;
    for (int n = 0; n < n_words; n++) begin
      if (n % 64 == 0) in_calm = ($urandom_range(0, 2) == 0);
      if (n == n_words - quiet_words) tail_quiet = 1'b1;
      c = ($urandom_range(0, 15) == 0) ? CMD_UNUSED : CMD_W'($urandom_range(0, 2));
      idx = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom) : pick_index();
      send_word(c, idx, $urandom);
    end
  endtask

  task automatic finish_run();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_answers.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    // catch any stray word after the last answer
    repeat (40) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch($sformatf("%0d answers never came", pending_answers.size()));
    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  endtask

  initial begin : run
    foreach (tree_node[k]) tree_node[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset holds in_stall high; send_word just waits
    test_empty_tree();
    test_counts_and_search(500);
    test_drain_pause();
    test_extreme_values();
    test_random_noise(550, 120);
    finish_run();
  end

  // worst-case time per word plus the clearing pass, taken many times over
  initial begin : watchdog
    #(2_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
